/* sv/ptw_pkg.sv */
// Shared constants, types and helpers of the Sv39 page-table walker.
`timescale 1ns / 1ps
package ptw_pkg;

    localparam int TABLE_PAGES       = 64;
    localparam int ENTRIES_PER_TABLE = 512;
    localparam int ENTRY_W           = 9;
    localparam int PAGE_W            = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
    localparam int ADDR_W            = PAGE_W + ENTRY_W;
    localparam int DEPTH             = TABLE_PAGES * ENTRIES_PER_TABLE;
    localparam int WORD_W            = 64;
    localparam int PPN_W             = 44;
    localparam int VA_W              = 39;
    localparam int PA_W              = 56;
    localparam int CFG_DATA_W        = 44;

    localparam int PTE_VALID_BIT = 0;
    localparam int PTE_USER_BIT  = 4;

    // Command codes.
    localparam logic CMD_WRITE     = 1'b0;
    localparam logic CMD_TRANSLATE = 1'b1;

    // Configuration register indexes.
    localparam logic REG_ROOT   = 1'b0;
    localparam logic REG_WINDOW = 1'b1;

    // Result status codes.
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_RANGE    = 3'd1;
    localparam logic [2:0] ST_UNMAPPED = 3'd2;
    localparam logic [2:0] ST_NOT_USER = 3'd3;
    localparam logic [2:0] ST_WINDOW   = 3'd4;

    typedef struct packed {
        logic                 we;
        logic [ADDR_W-1:0]    addr;
        logic [WORD_W-1:0]    wdata;
    } mem_req_t;

    // True when a 6-bit page number names a page that exists in the store.
    function automatic logic page_in_store(input logic [5:0] page);
        logic [11:0] wide;
        begin
            wide = {6'd0, page};
            page_in_store = (wide < 12'(TABLE_PAGES));
        end
    endfunction

endpackage

/* sv/sv39_page_table_walker.sv */
// Top level of the Sv39 page-table walker.
//
// Requests enter on start when busy is low: command 0 writes entry_word into
// entry store_entry of store page store_page, command 1 translates virt_addr.
// Every request gives exactly one result: done is high for one cycle with
// status and phys_addr; the receiver cannot stall, so the result must be taken.
// A write answers in the cycle after the request. A translation whose address is
// out of range, or whose root page is outside the store, also answers in the cycle
// after the request. A full walk makes three dependent reads of the single-port
// table store, each through its registered read, and then registers the result.
// busy is low again in the result cycle, so a new request may be given while the
// result is shown.
// Write configuration (cfg_we, cfg_index, cfg_data) only while the block is idle;
// the block does not enforce this. After reset it clears the whole store, one
// entry a cycle (32768 entries at default size); busy stays high until it is done.
`timescale 1ns / 1ps
module sv39_page_table_walker
    import ptw_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  command,
    input  logic [VA_W-1:0]       virt_addr,
    input  logic [5:0]            store_page,
    input  logic [ENTRY_W-1:0]    store_entry,
    input  logic [WORD_W-1:0]     entry_word,
    output logic                  done,
    output logic [2:0]            status,
    output logic [PA_W-1:0]       phys_addr,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    mem_req_t          req;
    logic [WORD_W-1:0] rdata;

    ptw_store u_store (
        .clk   (clk),
        .req   (req),
        .rdata (rdata)
    );

    ptw_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .command     (command),
        .virt_addr   (virt_addr),
        .store_page  (store_page),
        .store_entry (store_entry),
        .entry_word  (entry_word),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .rdata       (rdata),
        .req         (req),
        .busy        (busy),
        .done        (done),
        .status      (status),
        .phys_addr   (phys_addr)
    );

endmodule

/* sv/ptw_store.sv */
// Page-table store: single-port synchronous RAM with a registered read.
`timescale 1ns / 1ps
module ptw_store
    import ptw_pkg::*;
(
    input  logic              clk,
    input  mem_req_t          req,
    output logic [WORD_W-1:0] rdata
);

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
        rdata_reg <= mem[req.addr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/ptw_ctrl.sv */
// Walk sequencer: clearing pass, command decode, level checks and result registers.
`timescale 1ns / 1ps
module ptw_ctrl
    import ptw_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  command,
    input  logic [VA_W-1:0]       virt_addr,
    input  logic [5:0]            store_page,
    input  logic [ENTRY_W-1:0]    store_entry,
    input  logic [WORD_W-1:0]     entry_word,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [WORD_W-1:0]     rdata,
    output mem_req_t              req,
    output logic                  busy,
    output logic                  done,
    output logic [2:0]            status,
    output logic [PA_W-1:0]       phys_addr
);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_L2    = 5'b00100,
        S_L1    = 5'b01000,
        S_LEAF  = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   clr_reg, clr_next;
    logic [17:0]         idx_reg, idx_next;
    logic [5:0]          root_reg;
    logic [PPN_W-1:0]    base_reg;
    logic                done_reg, done_next;
    logic [2:0]          status_reg, status_next;
    logic [PA_W-1:0]     pa_reg, pa_next;

    logic [PPN_W-1:0]    pte_ppn;
    logic [PPN_W-1:0]    child_off;
    logic                child_outside;
    logic [PAGE_W-1:0]   child_page;

    // Child table check: the PPN must fall inside the window of store pages.
    assign pte_ppn       = rdata[10 +: PPN_W];
    assign child_off     = pte_ppn - base_reg;
    assign child_outside = (pte_ppn < base_reg) || (child_off >= PPN_W'(TABLE_PAGES));
    assign child_page    = child_off[PAGE_W-1:0];

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        idx_next    = idx_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        pa_next     = pa_reg;
        req.we      = 1'b0;
        req.addr    = {PAGE_W'(root_reg), virt_addr[38:30]};
        req.wdata   = entry_word;

        case (state_reg)
            S_CLEAR:
            begin
                req.we    = 1'b1;
                req.addr  = clr_reg;
                req.wdata = '0;
                if (clr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    if (command == CMD_WRITE)
                    begin
                        req.we      = page_in_store(store_page);
                        req.addr    = {PAGE_W'(store_page), store_entry};
                        done_next   = 1'b1;
                        status_next = ST_OK;
                        pa_next     = '0;
                    end
                    else if (virt_addr[VA_W-1])
                    begin
                        done_next   = 1'b1;
                        status_next = ST_RANGE;
                        pa_next     = '0;
                    end
                    else if (!page_in_store(root_reg))
                    begin
                        done_next   = 1'b1;
                        status_next = ST_WINDOW;
                        pa_next     = '0;
                    end
                    else
                    begin
                        // The root read is issued at the accept edge.
                        idx_next   = virt_addr[29:12];
                        state_next = S_L2;
                    end
                end
            end
            S_L2, S_L1:
            begin
                if (!rdata[PTE_VALID_BIT])
                begin
                    done_next   = 1'b1;
                    status_next = ST_UNMAPPED;
                    pa_next     = '0;
                    state_next  = S_IDLE;
                end
                else if (child_outside)
                begin
                    done_next   = 1'b1;
                    status_next = ST_WINDOW;
                    pa_next     = '0;
                    state_next  = S_IDLE;
                end
                else if (state_reg == S_L2)
                begin
                    req.addr   = {child_page, idx_reg[17:9]};
                    state_next = S_L1;
                end
                else
                begin
                    req.addr   = {child_page, idx_reg[8:0]};
                    state_next = S_LEAF;
                end
            end
            S_LEAF:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
                if (!rdata[PTE_VALID_BIT])
                begin
                    status_next = ST_UNMAPPED;
                    pa_next     = '0;
                end
                else if (!rdata[PTE_USER_BIT])
                begin
                    status_next = ST_NOT_USER;
                    pa_next     = '0;
                end
                else
                begin
                    status_next = ST_OK;
                    pa_next     = {pte_ppn, 12'd0};
                end
            end
            default:
            begin
                state_next = S_CLEAR;
                clr_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
            root_reg  <= '0;
            base_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ROOT:   root_reg <= cfg_data[5:0];
                    REG_WINDOW: base_reg <= cfg_data[PPN_W-1:0];
                    default:    ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        status_reg <= status_next;
        pa_reg     <= pa_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign status    = status_reg;
    assign phys_addr = pa_reg;

endmodule

/* sv/ptw_checker.sv */
// Port-level assertions for the Sv39 page-table walker, bound to the top level.
`timescale 1ns / 1ps
module ptw_checker
    import ptw_pkg::*;
(
    input logic            clk,
    input logic            rst_n,
    input logic            start,
    input logic            busy,
    input logic            command,
    input logic            done,
    input logic [2:0]      status,
    input logic [PA_W-1:0] phys_addr
);

    // A result is only shown once the block is free for the next request.
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    // A failed translation never leaks an address.
    a_err_zero_pa: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_OK) |-> (phys_addr == '0))
        else $error("nonzero address with error status");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == ST_OK || status == ST_RANGE || status == ST_UNMAPPED ||
                  status == ST_NOT_USER || status == ST_WINDOW))
        else $error("undefined status code");

    // A write answers in the next cycle with a clean ok result.
    a_write_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && command == CMD_WRITE) |=>
            (done && status == ST_OK && phys_addr == '0))
        else $error("write request did not answer ok");

    // An accepted request either answers at once or keeps the block busy.
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("request dropped");

endmodule

bind sv39_page_table_walker ptw_checker u_ptw_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .command   (command),
    .done      (done),
    .status    (status),
    .phys_addr (phys_addr)
);

/* tb/tb_sv39_page_table_walker.sv */
// Self-checking testbench for the Sv39 page-table walker: directed table plus random walks.
`timescale 1ns / 1ps
module tb_sv39_page_table_walker;
    import ptw_pkg::*;

    localparam int RANDOM_ITEMS = 1300;
    localparam int PHASES       = 5;
    localparam int SETTLE_LIMIT = 200;
    localparam int DIRECTED_ROWS = 21;
    localparam logic [PPN_W-1:0] PPN_MAX = {PPN_W{1'b1}};

    typedef struct packed {
        logic [2:0]      status;
        logic [PA_W-1:0] phys_addr;
    } walk_result_t;

    typedef struct packed {
        logic               cmd;
        logic [VA_W-1:0]    va;
        logic [5:0]         page;
        logic [ENTRY_W-1:0] entry;
        logic [WORD_W-1:0]  word;
        logic               known;
        logic [2:0]         status;
        logic [PA_W-1:0]    pa;
    } directed_row_t;

    typedef enum int {
        FAULT_NONE,
        FAULT_L2_INVALID,
        FAULT_L1_INVALID,
        FAULT_LEAF_INVALID,
        FAULT_NOT_USER,
        FAULT_L2_WINDOW,
        FAULT_L1_WINDOW
    } fault_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic                  command = CMD_WRITE;
    logic [VA_W-1:0]       virt_addr = '0;
    logic [5:0]            store_page = '0;
    logic [ENTRY_W-1:0]    store_entry = '0;
    logic [WORD_W-1:0]     entry_word = '0;
    logic                  done;
    logic [2:0]            status;
    logic [PA_W-1:0]       phys_addr;
    logic                  cfg_we = 1'b0;
    logic                  cfg_index = REG_ROOT;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Mirror of the walker's table store and registers.
    logic [WORD_W-1:0] pte_mirror [DEPTH];
    logic [5:0]        root_cfg = '0;
    logic [PPN_W-1:0]  window_base_cfg = '0;

    walk_result_t    expected_walks [$];
    logic [VA_W-1:0] mapped_vas [$];
    logic [VA_W-1:0] last_va = '0;
    logic [5:0]      last_leaf_page = '0;
    bit              have_path = 1'b0;
    bit              idling_on = 1'b1;
    int              requests_sent = 0;
    int              mismatches = 0;

    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        '{CMD_TRANSLATE, 39'h0,            6'd0,  9'd0,   64'h0,
          1'b1, ST_UNMAPPED, 56'h0},
        '{CMD_TRANSLATE, 39'h40_0000_0000, 6'd0,  9'd0,   64'h0,
          1'b1, ST_RANGE,    56'h0},
        '{CMD_TRANSLATE, 39'h7F_FFFF_FFFF, 6'd0,  9'd0,   64'h0,
          1'b1, ST_RANGE,    56'h0},
        '{CMD_WRITE,     39'h0,            6'd0,  9'd0,   64'h401,
          1'b1, ST_OK,       56'h0},
        '{CMD_WRITE,     39'h0,            6'd1,  9'd0,   64'h801,
          1'b1, ST_OK,       56'h0},
        '{CMD_WRITE,     39'h0,            6'd2,  9'd0,   64'hFFFF_FFFF_FFFF_FC11,
          1'b1, ST_OK,       56'h0},
        '{CMD_TRANSLATE, 39'h0,            6'd0,  9'd0,   64'h0,
          1'b1, ST_OK,       56'hFF_FFFF_FFFF_F000},
        '{CMD_WRITE,     39'h0,            6'd2,  9'd1,   64'h1,
          1'b1, ST_OK,       56'h0},
        '{CMD_TRANSLATE, 39'h1FFF,         6'd0,  9'd0,   64'h0,
          1'b1, ST_NOT_USER, 56'h0},
        '{CMD_WRITE,     39'h0,            6'd0,  9'd1,   64'h10001,
          1'b1, ST_OK,       56'h0},
        '{CMD_TRANSLATE, 39'h4000_0000,    6'd0,  9'd0,   64'h0,
          1'b1, ST_WINDOW,   56'h0},
        '{CMD_WRITE,     39'h0,            6'd0,  9'd2,   64'h41F,
          1'b1, ST_OK,       56'h0},
        '{CMD_TRANSLATE, 39'h8000_0000,    6'd0,  9'd0,   64'h0,
          1'b0, ST_OK,       56'h0},
        '{CMD_WRITE,     39'h0,            6'd1,  9'd511, 64'hFFC0_0000_0000_0C01,
          1'b1, ST_OK,       56'h0},
        '{CMD_WRITE,     39'h0,            6'd3,  9'd511, 64'hFC11,
          1'b1, ST_OK,       56'h0},
        '{CMD_TRANSLATE, 39'h3FFF_FFFF,    6'd0,  9'd0,   64'h0,
          1'b0, ST_OK,       56'h0},
        '{CMD_WRITE,     39'h0,            6'd63, 9'd511, 64'hFFFF_FFFF_FFFF_FFFF,
          1'b1, ST_OK,       56'h0},
        '{CMD_WRITE,     39'h0,            6'd0,  9'd255, 64'hFC01,
          1'b1, ST_OK,       56'h0},
        '{CMD_TRANSLATE, 39'h3F_FFFF_FFFF, 6'd0,  9'd0,   64'h0,
          1'b0, ST_OK,       56'h0},
        '{CMD_WRITE,     39'h0,            6'd2,  9'd1,   64'h0,
          1'b1, ST_OK,       56'h0},
        '{CMD_TRANSLATE, 39'h1000,         6'd0,  9'd0,   64'h0,
          1'b1, ST_UNMAPPED, 56'h0}
    };

    sv39_page_table_walker u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .command     (command),
        .virt_addr   (virt_addr),
        .store_page  (store_page),
        .store_entry (store_entry),
        .entry_word  (entry_word),
        .done        (done),
        .status      (status),
        .phys_addr   (phys_addr),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        foreach (pte_mirror[i])
            pte_mirror[i] = '0;
    end

    function automatic logic [63:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [WORD_W-1:0] mirror_read(input int unsigned page,
                                                      input logic [ENTRY_W-1:0] entry);
        if (page >= TABLE_PAGES)
            return '0;
        return pte_mirror[page * ENTRIES_PER_TABLE + int'(entry)];
    endfunction

    // Applies one request to the mirror and returns the answer the walker must give.
    function automatic walk_result_t predict_walk(input logic cmd,
                                                  input logic [VA_W-1:0] va,
                                                  input logic [5:0] page,
                                                  input logic [ENTRY_W-1:0] entry,
                                                  input logic [WORD_W-1:0] word);
        walk_result_t      res;
        int unsigned       table_page;
        logic [WORD_W-1:0] pte;
        logic [PPN_W-1:0]  ppn;
        res = '0;
        if (cmd == CMD_WRITE)
        begin
            if (int'(page) < TABLE_PAGES)
                pte_mirror[int'(page) * ENTRIES_PER_TABLE + int'(entry)] = word;
            return res;
        end
        if (va[VA_W-1])
        begin
            res.status = ST_RANGE;
            return res;
        end
        table_page = 32'(root_cfg);
        if (table_page >= TABLE_PAGES)
        begin
            res.status = ST_WINDOW;
            return res;
        end
        // Upper levels need only the valid bit; their permission bits are ignored.
        for (int level = 2; level > 0; level--)
        begin
            pte = mirror_read(table_page, va[12 + ENTRY_W * level +: ENTRY_W]);
            if (!pte[PTE_VALID_BIT])
            begin
                res.status = ST_UNMAPPED;
                return res;
            end
            ppn = pte[10 +: PPN_W];
            if (ppn < window_base_cfg || (ppn - window_base_cfg) >= PPN_W'(TABLE_PAGES))
            begin
                res.status = ST_WINDOW;
                return res;
            end
            table_page = int'(ppn - window_base_cfg);
        end
        pte = mirror_read(table_page, va[12 +: ENTRY_W]);
        if (!pte[PTE_VALID_BIT])
            res.status = ST_UNMAPPED;
        else if (!pte[PTE_USER_BIT])
            res.status = ST_NOT_USER;
        else
        begin
            res.status    = ST_OK;
            res.phys_addr = {pte[10 +: PPN_W], 12'h000};
        end
        return res;
    endfunction

    // Highest store page that a child pointer can reach under the current window.
    function automatic int window_room();
        logic [PPN_W-1:0] left;
        left = PPN_MAX - window_base_cfg;
        return (left < PPN_W'(TABLE_PAGES - 1)) ? int'(left) : TABLE_PAGES - 1;
    endfunction

    function automatic logic [PPN_W-1:0] outside_ppn();
        logic [PPN_W-1:0] gap;
        gap = PPN_W'($urandom_range(255));
        if (window_base_cfg > PPN_MAX - 320 || (window_base_cfg >= 256 && $urandom_range(1)))
            return window_base_cfg - 1 - gap;
        return window_base_cfg + PPN_W'(TABLE_PAGES) + gap;
    endfunction

    function automatic logic [WORD_W-1:0] pointer_pte(input logic [PPN_W-1:0] ppn,
                                                      input logic valid);
        logic [63:0] r;
        r = rand_word();
        return {r[63:54], ppn, r[9:1], valid};
    endfunction

    function automatic logic [WORD_W-1:0] leaf_pte(input logic [PPN_W-1:0] ppn,
                                                   input logic valid, input logic user);
        logic [63:0] r;
        r = rand_word();
        return {r[63:54], ppn, r[9:5], user, r[3:1], valid};
    endfunction

    // Drives one request, waits for it to be taken and records its expected answer.
    task automatic send_request(input logic cmd, input logic [VA_W-1:0] va,
                                input logic [5:0] page, input logic [ENTRY_W-1:0] entry,
                                input logic [WORD_W-1:0] word, input logic known,
                                input walk_result_t answer);
        walk_result_t predicted;
        while (idling_on && $urandom_range(99) < 9)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start       <= 1'b1;
        command     <= cmd;
        virt_addr   <= va;
        store_page  <= page;
        store_entry <= entry;
        entry_word  <= word;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predicted = predict_walk(cmd, va, page, entry, word);
        expected_walks.push_back(known ? answer : predicted);
        requests_sent++;
    endtask

    task automatic write_pte(input logic [5:0] page, input logic [ENTRY_W-1:0] entry,
                             input logic [WORD_W-1:0] word);
        logic [63:0] r;
        r = rand_word();
        send_request(CMD_WRITE, r[VA_W-1:0], page, entry, word, 1'b0, '0);
    endtask

    task automatic translate(input logic [VA_W-1:0] va);
        logic [63:0] r;
        r = rand_word();
        send_request(CMD_TRANSLATE, va, r[5:0], r[14:6], rand_word(), 1'b0, '0);
    endtask

    // Builds a three-level path for a random address, optionally breaks it, then walks it.
    task automatic walk_sequence(input fault_t fault);
        logic [63:0]      r;
        logic [VA_W-1:0]  va;
        logic [5:0]       mid_page;
        logic [5:0]       leaf_page;
        logic [PPN_W-1:0] l2_ppn;
        logic [PPN_W-1:0] l1_ppn;
        int               room;
        r    = rand_word();
        room = window_room();
        if (have_path && fault == FAULT_NONE && $urandom_range(99) < 30)
        begin
            // Reuse the upper two levels of the previous path.
            va        = {last_va[VA_W-1:21], r[20:0]};
            leaf_page = last_leaf_page;
        end
        else
        begin
            va        = {1'b0, r[37:0]};
            mid_page  = 6'($urandom_range(room));
            leaf_page = 6'($urandom_range(room));
            l2_ppn = (fault == FAULT_L2_WINDOW) ? outside_ppn()
                                                : window_base_cfg + PPN_W'(mid_page);
            l1_ppn = (fault == FAULT_L1_WINDOW) ? outside_ppn()
                                                : window_base_cfg + PPN_W'(leaf_page);
            write_pte(root_cfg, va[38:30], pointer_pte(l2_ppn, fault != FAULT_L2_INVALID));
            write_pte(mid_page, va[29:21], pointer_pte(l1_ppn, fault != FAULT_L1_INVALID));
        end
        r = rand_word();
        write_pte(leaf_page, va[20:12],
                  leaf_pte(r[PPN_W-1:0], fault != FAULT_LEAF_INVALID, fault != FAULT_NOT_USER));
        translate(va);
        if (fault == FAULT_NONE)
        begin
            last_va        = va;
            last_leaf_page = leaf_page;
            have_path      = 1'b1;
            mapped_vas.push_back(va);
            if (mapped_vas.size() > 64)
                void'(mapped_vas.pop_front());
        end
    endtask

    // Stops issuing and waits until every outstanding result has come back.
    task automatic settle_walker();
        int waited;
        waited = 0;
        start <= 1'b0;
        while (expected_walks.size() != 0 && waited < SETTLE_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (expected_walks.size() != 0)
        begin
            $error("%0d results never arrived", expected_walks.size());
            mismatches++;
            expected_walks.delete();
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic program_walker(input logic [5:0] root, input logic [PPN_W-1:0] base);
        cfg_we    <= 1'b1;
        cfg_index <= REG_ROOT;
        cfg_data  <= CFG_DATA_W'(root);
        @(posedge clk);
        cfg_index <= REG_WINDOW;
        cfg_data  <= base;
        @(posedge clk);
        cfg_we <= 1'b0;
        root_cfg        = root;
        window_base_cfg = base;
    endtask

    always @(posedge clk)
    begin : result_check
        walk_result_t want;
        if (rst_n && done)
        begin
            if (expected_walks.size() == 0)
            begin
                $error("result with no request outstanding: status %0d, phys_addr 0x%0h",
                       status, phys_addr);
                mismatches++;
            end
            else
            begin
                want = expected_walks.pop_front();
                if (status !== want.status)
                begin
                    $error("status mismatch: expected %0d, actual %0d", want.status, status);
                    mismatches++;
                end
                if (phys_addr !== want.phys_addr)
                begin
                    $error("phys_addr mismatch: expected 0x%0h, actual 0x%0h",
                           want.phys_addr, phys_addr);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        logic [63:0]      r;
        logic [5:0]       root;
        logic [PPN_W-1:0] base;
        int               pick;
        int               phase_end;
        walk_result_t     answer;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        // The store is cleared after reset; busy holds until that pass is over.
        @(posedge clk);
        while (busy)
            @(posedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            answer.status    = directed_rows[i].status;
            answer.phys_addr = directed_rows[i].pa;
            send_request(directed_rows[i].cmd, directed_rows[i].va, directed_rows[i].page,
                         directed_rows[i].entry, directed_rows[i].word,
                         directed_rows[i].known, answer);
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            r = rand_word();
            case (phase)
                0:
                begin
                    root = 6'd63;
                    base = '0;
                end
                1:
                begin
                    root = 6'd0;
                    base = PPN_MAX;
                end
                2:
                begin
                    root = r[5:0];
                    base = PPN_MAX - PPN_W'(TABLE_PAGES - 1);
                end
                3:
                begin
                    root = r[5:0];
                    base = r[63:20];
                end
                default:
                begin
                    root = r[5:0];
                    base = PPN_W'($urandom_range(1000, 300));
                end
            endcase
            // One phase runs back to back with no gaps between requests.
            idling_on = (phase != 2);
            settle_walker();
            program_walker(root, base);
            phase_end = requests_sent + RANDOM_ITEMS / PHASES;
            while (requests_sent < phase_end)
            begin
                pick = $urandom_range(99);
                r    = rand_word();
                if (pick < 55)
                    walk_sequence(FAULT_NONE);
                else if (pick < 70)
                    walk_sequence(fault_t'($urandom_range(FAULT_L1_WINDOW, FAULT_L2_INVALID)));
                else if (pick < 85 && mapped_vas.size() != 0)
                    translate({mapped_vas[$urandom_range(mapped_vas.size() - 1)][VA_W-1:12],
                               r[11:0]});
                else if (pick < 93)
                    write_pte(r[5:0], r[14:6], rand_word());
                else
                    translate(r[VA_W-1:0]);
            end
        end

        settle_walker();
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

/* files.f */
sv/ptw_pkg.sv
sv/ptw_store.sv
sv/ptw_ctrl.sv
sv/sv39_page_table_walker.sv
sv/ptw_checker.sv
tb/tb_sv39_page_table_walker.sv
